### hdl/aekd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aekd_pkg - shared types and constants of the escape-sequence key decoder
// Byte codes, status and kind codes, key identifiers, the decoder state
// record and the result record.
// ----------------------------------------------------------------------------
package aekd_pkg;

	// Sizing
	localparam int MAX_PARAMS = 4;
	localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
	localparam int PARAM_W    = 16;

	// Byte codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_D  = 8'h44;
	localparam logic [7:0] CH_UC_M  = 8'h4D;
	localparam logic [7:0] CH_UC_P  = 8'h50;
	localparam logic [7:0] CH_UC_R  = 8'h52;
	localparam logic [7:0] CH_UC_S  = 8'h53;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	// Key identifiers (dense, table order)
	localparam logic [4:0] KEY_NONE        = 5'd0;
	localparam logic [4:0] KEY_SCROLL_DOWN = 5'd1;
	localparam logic [4:0] KEY_SCROLL_UP   = 5'd2;
	localparam logic [4:0] KEY_F1          = 5'd3;
	localparam logic [4:0] KEY_CPR         = 5'd7;
	localparam logic [4:0] KEY_HOME        = 5'd8;
	localparam logic [4:0] KEY_UP          = 5'd22;
	localparam logic [4:0] KEY_LAST        = 5'd25;

	localparam int TILDE_KEYS = 14;
	localparam logic [7:0] TILDE_NUM [TILDE_KEYS] = '{
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd15, 8'd17,
		8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd24
	};

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_INVALID    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_ESC_LETTER = 3'd1,
		KIND_SS3_LETTER = 3'd2,
		KIND_CSI_LETTER = 3'd3,
		KIND_CSI_TILDE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_ESC_O,
		PH_CSI
	} phase_t;

	// Parser state; only the first two stored parameters are ever reported
	typedef struct packed {
		phase_t               phase;
		logic [PARAM_W-1:0]   acc;
		logic                 digits_seen;
		logic [CNT_W-1:0]     total;
		logic [PARAM_W-1:0]   store0;
		logic [PARAM_W-1:0]   store1;
	} state_t;

	typedef struct packed {
		status_t              status;
		kind_t                code_kind;
		logic [4:0]           key_id;
		logic [7:0]           final_char;
		logic [PARAM_W-1:0]   tilde_number;
		logic [2:0]           param_count;
		logic [PARAM_W-1:0]   param_first;
		logic [PARAM_W-1:0]   param_second;
	} result_t;

	// Key id of a tilde sequence number, 0 when not named
	function automatic logic [4:0] tilde_key(input logic [PARAM_W-1:0] n);
		logic [4:0] k;
		k = KEY_NONE;
		for (int i = 0; i < TILDE_KEYS; i++) begin
			if (n == {{(PARAM_W-8){1'b0}}, TILDE_NUM[i]}) begin
				k = KEY_HOME + 5'(i);
			end
		end
		return k;
	endfunction

endpackage

### hdl/aekd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aekd_if - channel interfaces of the escape-sequence key decoder
// aekd_byte_if carries terminal bytes, aekd_key_if carries decode results.
// ----------------------------------------------------------------------------
interface aekd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface aekd_key_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  code_kind;
	logic [4:0]  key_id;
	logic [7:0]  final_char;
	logic [15:0] tilde_number;
	logic [2:0]  param_count;
	logic [15:0] param_first;
	logic [15:0] param_second;

	modport source (
		output valid, output status, output code_kind, output key_id,
		output final_char, output tilde_number, output param_count,
		output param_first, output param_second, input ready
	);
	modport sink (
		input valid, input status, input code_kind, input key_id,
		input final_char, input tilde_number, input param_count,
		input param_first, input param_second, output ready
	);
endinterface

### hdl/aekd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aekd_step - one-byte parser update
// Next parser state and the result for one received byte.
// ----------------------------------------------------------------------------
module aekd_step (
	input  aekd_pkg::state_t  cur,
	input  logic [7:0]        rx_byte,
	output aekd_pkg::state_t  nxt,
	output aekd_pkg::result_t res
);
	import aekd_pkg::*;

	logic                  is_letter;
	logic                  is_digit;
	logic                  store_full;
	logic                  need_push;
	logic [CNT_W-1:0]      total_new;
	logic [PARAM_W+3:0]    acc_next;

	// Byte classes
	assign is_letter = ((rx_byte >= CH_UC_A) && (rx_byte <= CH_UC_Z)) ||
	                   ((rx_byte >= CH_LC_A) && (rx_byte <= CH_LC_Z));
	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	// acc * 10 + digit, saturated below
	assign acc_next = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) +
	                  {{PARAM_W{1'b0}}, rx_byte[3:0]};

	assign store_full = (cur.total >= CNT_W'(MAX_PARAMS));
	assign need_push  = cur.digits_seen || (cur.total != '0);
	assign total_new  = cur.total + CNT_W'(need_push);

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_IDLE: begin
				if (rx_byte == CH_ESC) begin
					nxt.phase = PH_ESC;
				end else begin
					res.status = ST_INVALID;
				end
			end
			PH_ESC: begin
				if (rx_byte == CH_O) begin
					nxt.phase = PH_ESC_O;
				end else if (rx_byte == CH_LBRK) begin
					nxt.phase       = PH_CSI;
					nxt.acc         = '0;
					nxt.digits_seen = 1'b0;
					nxt.total       = '0;
				end else if (is_letter) begin
					res.status     = ST_COMPLETE;
					res.code_kind  = KIND_ESC_LETTER;
					res.final_char = rx_byte;
					if (rx_byte == CH_UC_D) begin
						res.key_id = KEY_SCROLL_DOWN;
					end else if (rx_byte == CH_UC_M) begin
						res.key_id = KEY_SCROLL_UP;
					end
				end else begin
					res.status = ST_INVALID;
				end
			end
			PH_ESC_O: begin
				if (is_letter) begin
					res.status     = ST_COMPLETE;
					res.code_kind  = KIND_SS3_LETTER;
					res.final_char = rx_byte;
					if ((rx_byte >= CH_UC_P) && (rx_byte <= CH_UC_S)) begin
						res.key_id = KEY_F1 + 5'(rx_byte - CH_UC_P);
					end
				end else begin
					res.status = ST_INVALID;
				end
			end
			PH_CSI: begin
				if (is_digit) begin
					// decimal accumulate, saturate at full scale
					nxt.acc = (acc_next[PARAM_W+3:PARAM_W] != '0) ? '1 :
					          acc_next[PARAM_W-1:0];
					nxt.digits_seen = 1'b1;
				end else if (rx_byte == CH_SEMI) begin
					if (store_full) begin
						res.status = ST_INVALID;
					end else begin
						nxt.total       = cur.total + CNT_W'(1);
						nxt.acc         = '0;
						nxt.digits_seen = 1'b0;
						if (cur.total == CNT_W'(0)) begin
							nxt.store0 = cur.acc;
						end
						if (cur.total == CNT_W'(1)) begin
							nxt.store1 = cur.acc;
						end
					end
				end else if (is_letter || (rx_byte == CH_TILDE)) begin
					if (need_push && store_full) begin
						res.status = ST_INVALID;
					end else if (rx_byte == CH_TILDE) begin
						// exactly one parameter, still held in the accumulator
						if ((cur.total == CNT_W'(0)) && cur.digits_seen) begin
							res.status       = ST_COMPLETE;
							res.code_kind    = KIND_CSI_TILDE;
							res.final_char   = rx_byte;
							res.tilde_number = cur.acc;
							res.key_id       = tilde_key(cur.acc);
						end else begin
							res.status = ST_INVALID;
						end
					end else begin
						res.status      = ST_COMPLETE;
						res.code_kind   = KIND_CSI_LETTER;
						res.final_char  = rx_byte;
						res.param_count = 3'(total_new);
						if (total_new > CNT_W'(0)) begin
							res.param_first = (cur.total == CNT_W'(0)) ? cur.acc :
							                  cur.store0;
						end
						if (total_new > CNT_W'(1)) begin
							res.param_second = (cur.total == CNT_W'(1)) ? cur.acc :
							                   cur.store1;
						end
						if (rx_byte == CH_UC_R) begin
							res.key_id = KEY_CPR;
						end else if ((rx_byte >= CH_UC_A) && (rx_byte <= CH_UC_D)) begin
							res.key_id = KEY_UP + 5'(rx_byte - CH_UC_A);
						end
					end
				end else begin
					res.status = ST_INVALID;
				end
			end
			default: begin
				res.status = ST_INVALID;
			end
		endcase

		// A finished sequence returns the parser to idle
		if (res.status != ST_INCOMPLETE) begin
			nxt.phase       = PH_IDLE;
			nxt.acc         = '0;
			nxt.digits_seen = 1'b0;
			nxt.total       = '0;
		end
	end

endmodule

### hdl/ansi_escape_key_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_key_decoder - terminal escape-sequence key decoder
//
//   channel   dir   payload                                   handshake
//   term      in    in_byte                                   valid/ready
//   result    out   status, code_kind, key_id, final_char,    valid/ready
//                   tilde_number, param_count, param_first,
//                   param_second
//
// One result per byte. A byte is held in the input register, is
// decoded there against the parser state and lands in the result register;
// one byte per cycle sustained while the result side takes every result.
// arst_n returns the parser to idle and empties both registers.
// A stalled result holds the pipeline; term.ready stays high while the
// input register is empty or can move into the result register.
// ----------------------------------------------------------------------------
module ansi_escape_key_decoder (
	input  logic                clk,
	input  logic                arst_n,
	aekd_byte_if.sink           term,
	aekd_key_if.source          result
);
	import aekd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    res_q;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic       advance;

	// Pipeline moves when the result register is free or being taken
	assign advance    = !out_valid_q || result.ready;
	assign term.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (term.ready) begin
			valid_s1 <= term.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (term.ready && term.valid) begin
			byte_s1 <= term.in_byte;
		end
	end

	aekd_step u_step (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// Parser control state and parameter store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_IDLE;
			state_q.acc         <= '0;
			state_q.digits_seen <= 1'b0;
			state_q.total       <= '0;
			state_q.store0      <= '0;
			state_q.store1      <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = res_q.status;
	assign result.code_kind    = res_q.code_kind;
	assign result.key_id       = res_q.key_id;
	assign result.final_char   = res_q.final_char;
	assign result.tilde_number = res_q.tilde_number;
	assign result.param_count  = res_q.param_count;
	assign result.param_first  = res_q.param_first;
	assign result.param_second = res_q.param_second;

endmodule

### hdl/aekd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aekd_checker - port-level checks of the escape-sequence key decoder
// Result encoding consistency and stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module aekd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [2:0]  code_kind,
	input logic [4:0]  key_id,
	input logic [7:0]  final_char,
	input logic [15:0] tilde_number,
	input logic [2:0]  param_count,
	input logic [15:0] param_first,
	input logic [15:0] param_second
);
	import aekd_pkg::*;

	// Only complete results carry fields
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_COMPLETE) |->
			(code_kind == KIND_NONE) && (key_id == KEY_NONE) && (final_char == 8'd0) &&
			(tilde_number == 16'd0) && (param_count == 3'd0) &&
			(param_first == 16'd0) && (param_second == 16'd0))
		else $error("fields set on a result that is not complete");

	// Complete results have a real kind and a named or zero key
	a_complete_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_COMPLETE) |->
			(code_kind != KIND_NONE) && (code_kind <= KIND_CSI_TILDE) &&
			(key_id <= KEY_LAST))
		else $error("complete result with bad kind or key");

	// Tilde sequences end in tilde and carry no listed parameters
	a_tilde_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (code_kind == KIND_CSI_TILDE) |->
			(final_char == CH_TILDE) && (param_count == 3'd0) &&
			(param_first == 16'd0) && (param_second == 16'd0))
		else $error("malformed tilde result");

	// Short escape forms carry no parameters
	a_short_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((code_kind == KIND_ESC_LETTER) || (code_kind == KIND_SS3_LETTER)) |->
			(tilde_number == 16'd0) && (param_count == 3'd0) &&
			(param_first == 16'd0) && (param_second == 16'd0))
		else $error("parameters on a short escape result");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(status) && $stable(key_id) && $stable(final_char) &&
			$stable(param_first) && $stable(param_second) && $stable(tilde_number))
		else $error("result changed while stalled");

endmodule

bind ansi_escape_key_decoder aekd_checker u_aekd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.status       (result.status),
	.code_kind    (result.code_kind),
	.key_id       (result.key_id),
	.final_char   (result.final_char),
	.tilde_number (result.tilde_number),
	.param_count  (result.param_count),
	.param_first  (result.param_first),
	.param_second (result.param_second)
);

### sim/ansi_escape_key_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_key_decoder_tb - self-checking bench of the escape key decoder
// Feeds terminal bytes: a short directed run, then random escape sequences
// with well-formed structure, broken sequences and stray bytes. A predictor
// class tracks the parser and checks every decoded result in order, while
// both channels stall at random and once the result side holds off long.
// ----------------------------------------------------------------------------
module ansi_escape_key_decoder_tb;
	import aekd_pkg::*;

	localparam int PLANNED_BYTES  = 1250;
	localparam int TAIL_BYTES     = 150;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PRINT_LIMIT    = 40;
	localparam int unsigned PARAM_LIMIT = 65535;

	// Predicts the decoder result of every transferred byte and checks them
	class esc_key_predictor;
		phase_t      cur_phase;
		int unsigned acc;
		bit          seen;
		int unsigned total;
		logic [15:0] store [MAX_PARAMS];
		result_t     expected_keys [$];
		int unsigned mismatch_count;

		function new();
			go_idle();
			foreach (store[i]) store[i] = '0;
			mismatch_count = 0;
		endfunction

		function void go_idle();
			cur_phase = PH_IDLE;
			acc       = 0;
			seen      = 1'b0;
			total     = 0;
		endfunction

		// Store the pending parameter; 0 when the store is full
		function bit store_param();
			if (total >= MAX_PARAMS) begin
				return 1'b0;
			end
			store[total] = acc[15:0];
			total++;
			acc  = 0;
			seen = 1'b0;
			return 1'b1;
		endfunction

		function logic [4:0] tilde_key_of(logic [15:0] n);
			case (n)
				1, 2, 3, 4, 5, 6:   return KEY_HOME + 5'(n - 1);
				15:                 return KEY_HOME + 5'd6;
				17, 18, 19, 20, 21: return KEY_HOME + 5'(n - 10);
				23, 24:             return KEY_HOME + 5'(n - 11);
				default:            return KEY_NONE;
			endcase
		endfunction

		// Advance the parser by one transferred byte and queue its result
		function void take_byte(logic [7:0] b);
			result_t     r;
			bit          alpha;
			int unsigned grown;
			r        = '0;
			r.status = ST_INCOMPLETE;
			alpha    = (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
			case (cur_phase)
				PH_IDLE: begin
					if (b == CH_ESC) cur_phase = PH_ESC;
					else r.status = ST_INVALID;
				end
				PH_ESC: begin
					if (b == CH_O) begin
						cur_phase = PH_ESC_O;
					end else if (b == CH_LBRK) begin
						cur_phase = PH_CSI;
						acc       = 0;
						seen      = 1'b0;
						total     = 0;
					end else if (alpha) begin
						r.status     = ST_COMPLETE;
						r.code_kind  = KIND_ESC_LETTER;
						r.final_char = b;
						r.key_id     = (b == CH_UC_D) ? KEY_SCROLL_DOWN :
							(b == CH_UC_M) ? KEY_SCROLL_UP : KEY_NONE;
					end else begin
						r.status = ST_INVALID;
					end
				end
				PH_ESC_O: begin
					if (alpha) begin
						r.status     = ST_COMPLETE;
						r.code_kind  = KIND_SS3_LETTER;
						r.final_char = b;
						r.key_id     = (b >= CH_UC_P && b <= CH_UC_S) ?
							KEY_F1 + 5'(b - CH_UC_P) : KEY_NONE;
					end else begin
						r.status = ST_INVALID;
					end
				end
				default: begin
					if (b >= CH_ZERO && b <= CH_NINE) begin
						grown = acc * 10 + 32'(b - CH_ZERO);
						acc   = (grown > PARAM_LIMIT) ? PARAM_LIMIT : grown;
						seen  = 1'b1;
					end else if (b == CH_SEMI) begin
						if (!store_param()) r.status = ST_INVALID;
					end else if (alpha || b == CH_TILDE) begin
						// empty last field counts only after a separator
						if ((seen || total != 0) && !store_param()) begin
							r.status = ST_INVALID;
						end else if (b == CH_TILDE) begin
							if (total != 1) begin
								r.status = ST_INVALID;
							end else begin
								r.status       = ST_COMPLETE;
								r.code_kind    = KIND_CSI_TILDE;
								r.final_char   = b;
								r.tilde_number = store[0];
								r.key_id       = tilde_key_of(store[0]);
							end
						end else begin
							r.status       = ST_COMPLETE;
							r.code_kind    = KIND_CSI_LETTER;
							r.final_char   = b;
							r.param_count  = 3'(total);
							r.param_first  = (total > 0) ? store[0] : '0;
							r.param_second = (total > 1) ? store[1] : '0;
							if (b == CH_UC_R) r.key_id = KEY_CPR;
							else if (b >= CH_UC_A && b <= CH_UC_D) r.key_id = KEY_UP + 5'(b - CH_UC_A);
						end
					end else begin
						r.status = ST_INVALID;
					end
				end
			endcase
			if (r.status != ST_INCOMPLETE) go_idle();
			expected_keys.insert(expected_keys.size(), r);
		endfunction

		task report(string msg);
			mismatch_count++;
			if (mismatch_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
		endtask

		// Compare one transferred result against the oldest prediction
		task check_key(result_t got);
			result_t want;
			if (expected_keys.size() == 0) begin
				report("result transfer with no byte outstanding");
				return;
			end
			want = expected_keys.pop_front();
			check_field("status", 16'(got.status), 16'(want.status));
			check_field("code_kind", 16'(got.code_kind), 16'(want.code_kind));
			check_field("key_id", 16'(got.key_id), 16'(want.key_id));
			check_field("final_char", 16'(got.final_char), 16'(want.final_char));
			check_field("tilde_number", got.tilde_number, want.tilde_number);
			check_field("param_count", 16'(got.param_count), 16'(want.param_count));
			check_field("param_first", got.param_first, want.param_first);
			check_field("param_second", got.param_second, want.param_second);
		endtask
	endclass

	logic clk;
	logic arst_n;

	aekd_byte_if term_ch ();
	aekd_key_if  key_ch ();

	ansi_escape_key_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_ch),
		.result (key_ch)
	);

	esc_key_predictor sb;
	logic [7:0]       byte_plan [$];
	bit               long_hold = 1'b0;
	bit               calm_tail = 1'b0;
	int               quiet_cycles = 0;

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---- byte planning ----

	function automatic logic [7:0] random_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? CH_UC_A : CH_LC_A;
		return base + 8'($urandom_range(25));
	endfunction

	function automatic void plan_byte(logic [7:0] b);
		byte_plan.insert(byte_plan.size(), b);
	endfunction

	function automatic void plan_text(string s);
		for (int k = 0; k < s.len(); k++) plan_byte(s[k]);
	endfunction

	function automatic void plan_esc(string s);
		plan_byte(CH_ESC);
		plan_text(s);
	endfunction

	function automatic void plan_directed();
		plan_byte(8'h00);             // stray byte while idle
		plan_esc("D");                // scroll down
		plan_esc("OS");               // F4
		plan_esc("[A");               // arrow with no parameters
		plan_esc("[1;5C");            // two parameters
		plan_esc("[99999~");          // tilde number saturates
		plan_esc("[;;;;R");           // one parameter too many
		plan_byte(CH_ESC);            // ESC with a non-letter
		plan_byte(8'hFF);
	endfunction

	// One random sequence: mostly well formed, some noise or corruption
	function automatic void plan_random_sequence();
		logic [7:0]  seq [$];
		int unsigned pick;
		int unsigned nparams;
		bit          tilde;
		string       finals;
		string       num;
		finals = "ABCDR";
		pick   = $urandom_range(99);
		if (pick < 10) begin
			seq.insert(seq.size(), 8'($urandom_range(255)));
		end else if (pick < 25) begin
			seq.insert(seq.size(), CH_ESC);
			case ($urandom_range(5))
				0:       seq.insert(seq.size(), CH_UC_D);
				1:       seq.insert(seq.size(), CH_UC_M);
				2:       seq.insert(seq.size(), 8'($urandom_range(255)));
				default: seq.insert(seq.size(), random_letter());
			endcase
		end else if (pick < 40) begin
			seq.insert(seq.size(), CH_ESC);
			seq.insert(seq.size(), CH_O);
			case ($urandom_range(4))
				0, 1:    seq.insert(seq.size(), CH_UC_P + 8'($urandom_range(3)));
				2:       seq.insert(seq.size(), 8'($urandom_range(255)));
				default: seq.insert(seq.size(), random_letter());
			endcase
		end else begin
			tilde   = $urandom_range(99) < 35;
			nparams = $urandom_range(MAX_PARAMS + 1);
			if (tilde && $urandom_range(3) != 0) nparams = 1;
			seq.insert(seq.size(), CH_ESC);
			seq.insert(seq.size(), CH_LBRK);
			for (int i = 0; i < nparams; i++) begin
				if (i > 0) seq.insert(seq.size(), CH_SEMI);
				pick = $urandom_range(99);
				if (pick < 12) begin
					// empty field
				end else if (pick < 60) begin
					num = $sformatf("%0d", $urandom_range(30));
					for (int k = 0; k < num.len(); k++) seq.insert(seq.size(), num[k]);
				end else begin
					// raw digits: leading zeros and saturation
					repeat ($urandom_range(1, 7))
						seq.insert(seq.size(), CH_ZERO + 8'($urandom_range(9)));
				end
			end
			if (tilde) seq.insert(seq.size(), CH_TILDE);
			else if ($urandom_range(1)) seq.insert(seq.size(), finals[$urandom_range(4)]);
			else seq.insert(seq.size(), random_letter());
			if ($urandom_range(99) < 8) seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
		end
		foreach (seq[k]) plan_byte(seq[k]);
	endfunction

	// ---- driving ----

	// Offer one byte after an optional gap and wait for its transfer
	task automatic send_byte(input logic [7:0] b, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			term_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		term_ch.valid   <= 1'b1;
		term_ch.in_byte <= b;
		do @(posedge clk); while (term_ch.ready !== 1'b1);
		sb.take_byte(b);
	endtask

	initial begin : sender
		int gap;
		sb              = new();
		arst_n          = 1'b0;
		term_ch.valid   = 1'b0;
		term_ch.in_byte = '0;
		plan_directed();
		while (byte_plan.size() < PLANNED_BYTES) plan_random_sequence();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (byte_plan[i]) begin
			if (i == HOLD_AT) long_hold = 1'b1;
			if (i >= byte_plan.size() - TAIL_BYTES) calm_tail = 1'b1;
			gap = 0;
			if (!calm_tail && !long_hold && $urandom_range(3) == 0) gap = $urandom_range(1, 16);
			send_byte(byte_plan[i], gap);
		end
		@(negedge clk);
		term_ch.valid <= 1'b0;

		// drain, then give the pipeline time to show any stray result
		while (sb.expected_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result-side ready: random bursts, one long hold-off, steady at the end
	initial begin : receiver
		int   span;
		logic level;
		bit   in_hold;
		key_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			in_hold = long_hold;
			if (in_hold) begin
				level = 1'b0;
				span  = HOLD_CYCLES;
			end else if (calm_tail) begin
				level = 1'b1;
				span  = 1;
			end else begin
				level = ($urandom_range(9) < 6);
				span  = $urandom_range(1, 16);
			end
			@(negedge clk);
			key_ch.ready <= level;
			repeat (span - 1) @(negedge clk);
			if (in_hold) long_hold = 1'b0;
		end
	end

	// ---- result monitor and watchdog ----

	always @(posedge clk) begin
		result_t got;
		got.status       = status_t'(key_ch.status);
		got.code_kind    = kind_t'(key_ch.code_kind);
		got.key_id       = key_ch.key_id;
		got.final_char   = key_ch.final_char;
		got.tilde_number = key_ch.tilde_number;
		got.param_count  = key_ch.param_count;
		got.param_first  = key_ch.param_first;
		got.param_second = key_ch.param_second;
		if (arst_n === 1'b1 && key_ch.valid === 1'b1 && key_ch.ready === 1'b1) begin
			sb.check_key(got);
		end

		// count cycles without a transfer on either channel
		if ((term_ch.valid === 1'b1 && term_ch.ready === 1'b1) ||
			(key_ch.valid === 1'b1 && key_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
